// ===== design/mcs51tiu_pkg.sv =====
// Shared types and constants for the MCS-51 timer and interrupt unit.
package mcs51tiu_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_EXT   = 2'd3
    } t_req;

    // Register selectors for counter byte and flag byte access
    localparam logic [2:0] SEL_LOW0  = 3'd0;
    localparam logic [2:0] SEL_HIGH0 = 3'd1;
    localparam logic [2:0] SEL_LOW1  = 3'd2;
    localparam logic [2:0] SEL_HIGH1 = 3'd3;
    localparam logic [2:0] SEL_FLAGS = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODES = 2'd0;
    localparam logic [1:0] CFG_RUN   = 2'd1;
    localparam logic [1:0] CFG_IE    = 2'd2;
    localparam logic [1:0] CFG_PWR   = 2'd3;

    // Timer modes
    localparam logic [1:0] MODE_13BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;
    localparam logic [1:0] MODE_SPLIT  = 2'd3;

    // Pending flag bit positions
    localparam int FLAG_IE0 = 0;
    localparam int FLAG_IE1 = 1;
    localparam int FLAG_TF0 = 2;
    localparam int FLAG_TF1 = 3;

    // Interrupt vectors
    localparam logic [4:0] VEC_IE0 = 5'h03;
    localparam logic [4:0] VEC_TF0 = 5'h0B;
    localparam logic [4:0] VEC_IE1 = 5'h13;
    localparam logic [4:0] VEC_TF1 = 5'h1B;
    localparam logic [4:0] VEC_NONE = 5'h00;

    typedef struct packed {
        t_req       req_type;
        logic [7:0] elapsed;
        logic [2:0] reg_sel;
        logic [7:0] write_data;
        logic       ext_line;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_taken;
        logic [4:0] irq_vector;
    } t_out;

    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

// ===== design/mcs51_timer_interrupt_unit_core.sv =====
// Top level of the MCS-51 timer and interrupt unit: request and result registers.
//
// Usage:
//   Requests (tick, counter byte write, byte read, external event) enter on
//   the input channel (i_in_valid / o_in_ready, payload i_in). Every request
//   returns exactly one result on the output channel (o_out_valid /
//   i_out_ready, payload o_out): read data, interrupt taken and vector.
//   Configuration registers (modes, run enables, interrupt enable, power control)
//   are written via i_cfg_we / i_cfg_idx / i_cfg_data, taking effect on the next
//   edge. The user must write only while no request is in flight (unenforced).
// Timing:
//   Accepted requests load the request register; one pass of timer and dispatch
//   logic then loads the result register once it is free or being taken.
//   One request per cycle is sustained while i_out_ready stays high.
// Reset (synchronous, active low) clears counters, flags, configuration
//   and both valid bits.
// Stall: when the receiver holds i_out_ready low, the result stays put,
//   one more request is held in the request register, then o_in_ready drops.
module mcs51_timer_interrupt_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcs51tiu_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mcs51tiu_pkg::t_out o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);

    logic               r_in_valid;
    mcs51tiu_pkg::t_in  r_in;
    logic               r_out_valid;
    mcs51tiu_pkg::t_out r_out;

    logic                  w_adv;
    logic                  w_step;
    mcs51tiu_pkg::t_out    w_res;
    mcs51tiu_pkg::t_cfg_wr w_cfg;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    mcs51tiu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/mcs51tiu_timer.sv =====
// Next-count logic for one timer in modes 0 to 2 (mode 3 handled by caller).
module mcs51tiu_timer (
    input  logic [1:0] i_mode,
    input  logic       i_run,
    input  logic [7:0] i_lo,
    input  logic [7:0] i_hi,
    input  logic [7:0] i_elapsed,
    output logic [7:0] o_lo,
    output logic [7:0] o_hi,
    output logic       o_ovf
);

    logic [13:0] w_sum13;
    logic [16:0] w_sum16;
    logic [8:0]  w_sum8;

    assign w_sum13 = {1'b0, i_hi, i_lo[4:0]} + {6'd0, i_elapsed};
    assign w_sum16 = {1'b0, i_hi, i_lo} + {9'd0, i_elapsed};
    assign w_sum8  = {1'b0, i_lo} + {1'b0, i_elapsed};

    // Mode select; a stopped timer holds
    always_comb begin
        o_lo  = i_lo;
        o_hi  = i_hi;
        o_ovf = 1'b0;
        if (i_run) begin
            unique case (i_mode)
                mcs51tiu_pkg::MODE_13BIT: begin
                    o_ovf = w_sum13[13];
                    if (w_sum13[13]) begin
                        o_lo = 8'd0;
                        o_hi = 8'd0;
                    end else begin
                        o_lo = {3'd0, w_sum13[4:0]};
                        o_hi = w_sum13[12:5];
                    end
                end
                mcs51tiu_pkg::MODE_16BIT: begin
                    o_ovf = w_sum16[16];
                    o_lo  = w_sum16[7:0];
                    o_hi  = w_sum16[15:8];
                end
                default: begin
                    // auto-reload: carry reloads from high byte plus remainder
                    o_ovf = w_sum8[8];
                    o_lo  = w_sum8[8] ? (i_hi + w_sum8[7:0]) : w_sum8[7:0];
                end
            endcase
        end
    end

endmodule

// ===== design/mcs51tiu_exec.sv =====
// Timer state, configuration registers and single-pass request execution.
module mcs51tiu_exec (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcs51tiu_pkg::t_cfg_wr i_cfg,
    input  logic                  i_step,
    input  mcs51tiu_pkg::t_in     i_item,
    output mcs51tiu_pkg::t_out    o_res
);

    logic [7:0] r_modes, r_ie;
    logic [1:0] r_run, r_pwr;
    logic [7:0] r_lo0, r_hi0, r_lo1, r_hi1;
    logic [3:0] r_flags;

    logic [7:0] n_lo0, n_hi0, n_lo1, n_hi1;
    logic [3:0] n_flags;

    logic [1:0] w_m0, w_m1;
    logic [7:0] w_t0_lo, w_t0_hi, w_t1_lo, w_t1_hi;
    logic       w_t0_ovf, w_t1_ovf;
    logic [8:0] w_split_lo, w_split_hi;
    logic [3:0] w_flags_tick;

    assign w_m0 = r_modes[1:0];
    assign w_m1 = r_modes[5:4];

    mcs51tiu_timer u_timer0 (
        .i_mode    (w_m0),
        .i_run     (r_run[0] && (w_m0 != mcs51tiu_pkg::MODE_SPLIT)),
        .i_lo      (r_lo0),
        .i_hi      (r_hi0),
        .i_elapsed (i_item.elapsed),
        .o_lo      (w_t0_lo),
        .o_hi      (w_t0_hi),
        .o_ovf     (w_t0_ovf)
    );

    mcs51tiu_timer u_timer1 (
        .i_mode    (w_m1),
        .i_run     (r_run[1] && (w_m1 != mcs51tiu_pkg::MODE_SPLIT)),
        .i_lo      (r_lo1),
        .i_hi      (r_hi1),
        .i_elapsed (i_item.elapsed),
        .o_lo      (w_t1_lo),
        .o_hi      (w_t1_hi),
        .o_ovf     (w_t1_ovf)
    );

    // Split mode on timer 0: two independent byte counters
    assign w_split_lo = {1'b0, r_lo0} + {1'b0, i_item.elapsed};
    assign w_split_hi = {1'b0, r_hi0} + {1'b0, i_item.elapsed};

    // Execute one request
    always_comb begin
        n_lo0   = r_lo0;
        n_hi0   = r_hi0;
        n_lo1   = r_lo1;
        n_hi1   = r_hi1;
        n_flags = r_flags;
        o_res   = '0;
        w_flags_tick = r_flags;
        unique case (i_item.req_type)
            mcs51tiu_pkg::REQ_TICK: begin
                if (!r_pwr[1]) begin
                    if (w_m0 == mcs51tiu_pkg::MODE_SPLIT) begin
                        if (r_run[0]) begin
                            n_lo0 = w_split_lo[7:0];
                            w_flags_tick[mcs51tiu_pkg::FLAG_TF0] = r_flags[mcs51tiu_pkg::FLAG_TF0]
                                | w_split_lo[8];
                        end
                        if (r_run[1]) begin
                            n_hi0 = w_split_hi[7:0];
                            w_flags_tick[mcs51tiu_pkg::FLAG_TF1] = r_flags[mcs51tiu_pkg::FLAG_TF1]
                                | w_split_hi[8];
                        end
                    end else begin
                        n_lo0 = w_t0_lo;
                        n_hi0 = w_t0_hi;
                        w_flags_tick[mcs51tiu_pkg::FLAG_TF0] = r_flags[mcs51tiu_pkg::FLAG_TF0]
                            | w_t0_ovf;
                    end
                    n_lo1 = w_t1_lo;
                    n_hi1 = w_t1_hi;
                    w_flags_tick[mcs51tiu_pkg::FLAG_TF1] = w_flags_tick[mcs51tiu_pkg::FLAG_TF1]
                        | w_t1_ovf;
                    n_flags = w_flags_tick;
                    // dispatch highest pending source
                    if (r_ie[7] && (r_ie[4:0] != 5'd0) && (w_flags_tick != 4'd0)) begin
                        o_res.irq_taken = 1'b1;
                        if (w_flags_tick[mcs51tiu_pkg::FLAG_TF1]) begin
                            n_flags[mcs51tiu_pkg::FLAG_TF1] = 1'b0;
                            o_res.irq_vector = mcs51tiu_pkg::VEC_TF1;
                        end else if (w_flags_tick[mcs51tiu_pkg::FLAG_TF0]) begin
                            n_flags[mcs51tiu_pkg::FLAG_TF0] = 1'b0;
                            o_res.irq_vector = mcs51tiu_pkg::VEC_TF0;
                        end else if (w_flags_tick[mcs51tiu_pkg::FLAG_IE1]) begin
                            n_flags[mcs51tiu_pkg::FLAG_IE1] = 1'b0;
                            o_res.irq_vector = mcs51tiu_pkg::VEC_IE1;
                        end else begin
                            n_flags[mcs51tiu_pkg::FLAG_IE0] = 1'b0;
                            o_res.irq_vector = mcs51tiu_pkg::VEC_IE0;
                        end
                    end
                end
            end
            mcs51tiu_pkg::REQ_WRITE: begin
                unique case (i_item.reg_sel)
                    mcs51tiu_pkg::SEL_LOW0:  n_lo0 = i_item.write_data;
                    mcs51tiu_pkg::SEL_HIGH0: n_hi0 = i_item.write_data;
                    mcs51tiu_pkg::SEL_LOW1:  n_lo1 = i_item.write_data;
                    mcs51tiu_pkg::SEL_HIGH1: n_hi1 = i_item.write_data;
                    mcs51tiu_pkg::SEL_FLAGS: n_flags = {i_item.write_data[7],
                        i_item.write_data[5], i_item.write_data[3], i_item.write_data[1]};
                    default: ;
                endcase
            end
            mcs51tiu_pkg::REQ_READ: begin
                unique case (i_item.reg_sel)
                    mcs51tiu_pkg::SEL_LOW0:  o_res.read_data = r_lo0;
                    mcs51tiu_pkg::SEL_HIGH0: o_res.read_data = r_hi0;
                    mcs51tiu_pkg::SEL_LOW1:  o_res.read_data = r_lo1;
                    mcs51tiu_pkg::SEL_HIGH1: o_res.read_data = r_hi1;
                    // TCON layout
                    mcs51tiu_pkg::SEL_FLAGS: o_res.read_data = {r_flags[3], r_run[1],
                        r_flags[2], r_run[0], r_flags[1], 1'b0, r_flags[0], 1'b0};
                    default: ;
                endcase
            end
            default: begin
                if (i_item.ext_line) n_flags[mcs51tiu_pkg::FLAG_IE1] = 1'b1;
                else                 n_flags[mcs51tiu_pkg::FLAG_IE0] = 1'b1;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
            r_run   <= '0;
            r_ie    <= '0;
            r_pwr   <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                mcs51tiu_pkg::CFG_MODES: r_modes <= i_cfg.data;
                mcs51tiu_pkg::CFG_RUN:   r_run   <= i_cfg.data[1:0];
                mcs51tiu_pkg::CFG_IE:    r_ie    <= i_cfg.data;
                default:                 r_pwr   <= i_cfg.data[1:0];
            endcase
        end
    end

    // Counter and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo0   <= '0;
            r_hi0   <= '0;
            r_lo1   <= '0;
            r_hi1   <= '0;
            r_flags <= '0;
        end else if (i_step) begin
            r_lo0   <= n_lo0;
            r_hi0   <= n_hi0;
            r_lo1   <= n_lo1;
            r_hi1   <= n_hi1;
            r_flags <= n_flags;
        end
    end

endmodule

// ===== design/mcs51tiu_checker.sv =====
// Port-level checker for the timer and interrupt unit, with its bind.
module mcs51tiu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mcs51tiu_pkg::t_out o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed under stall");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a taken interrupt carries one of the four vectors
    a_vec_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.irq_taken |->
            (o_out.irq_vector == mcs51tiu_pkg::VEC_TF1) ||
            (o_out.irq_vector == mcs51tiu_pkg::VEC_TF0) ||
            (o_out.irq_vector == mcs51tiu_pkg::VEC_IE1) ||
            (o_out.irq_vector == mcs51tiu_pkg::VEC_IE0))
        else $error("illegal interrupt vector");

    // dispatch and read data never share a result; no vector without dispatch
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.irq_taken |-> o_out.irq_vector == mcs51tiu_pkg::VEC_NONE)
        else $error("vector without dispatch");

    a_tick_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.irq_taken |-> o_out.read_data == 8'd0)
        else $error("read data on a dispatch");

endmodule

bind mcs51_timer_interrupt_unit_core mcs51tiu_checker u_mcs51tiu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
